>>> rtl/mpws_pkg.sv
// shared constants, types and the sine table for the metallic phase waveshaper
`default_nettype none

package mpws_pkg;

	// sine table geometry
	localparam int SINE_TABLE_BITS = 10;
	localparam int SINE_N          = 1 << SINE_TABLE_BITS;
	localparam int SINE_QUARTER    = SINE_N / 4;
	localparam int SINE_W          = 16;

	// field and datapath widths
	localparam int SAMPLE_W  = 16;
	localparam int INTENS_W  = 16;
	localparam int PHASE_W   = 16;
	localparam int ANGLE_W   = 32;
	localparam int FRAC_W    = 16;
	localparam int AMP_W     = 15;
	localparam int DRV_W     = 16;
	localparam int SPREAD_W  = 19;
	localparam int MUL_W     = 32;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int ACC_W     = 32;
	localparam int X_W       = 25;
	localparam int X2_W      = 26;
	localparam int DEN_W     = 30;
	localparam int QUOT_W    = 25;
	localparam int NUM_W     = DEN_W + QUOT_W;

	// intensity register
	localparam logic [INTENS_W-1:0] INTENS_RESET = 16'd16384;
	localparam logic [INTENS_W-1:0] INTENS_MAX   = 16'd32768;

	// intensity dependent terms, q15 coefficients
	localparam logic [PHASE_W-1:0]  PH_BASE     = 16'd1043;
	localparam logic [MUL_W-1:0]    K_PH        = 32'd2608;
	localparam logic [AMP_W-1:0]    AE_BASE     = 15'd8192;
	localparam logic [MUL_W-1:0]    K_AE        = 32'd9830;
	localparam logic [AMP_W-1:0]    AO_BASE     = 15'd4915;
	localparam logic [MUL_W-1:0]    K_AO        = 32'd6554;
	localparam logic [DRV_W-1:0]    DRV_BASE    = 16'd26214;
	localparam logic [MUL_W-1:0]    K_DRV       = 32'd13107;
	localparam logic [SPREAD_W-1:0] SPREAD_BASE = 19'd98304;
	localparam logic [SPREAD_W-1:0] MULT2_OFS   = 19'd131072;
	localparam logic [MUL_W-1:0]    TWO_OVER_PI = 32'd41722;
	localparam logic [DEN_W-1:0]    K27_Q24     = 30'd452984832;
	localparam logic [MUL_W-1:0]    OUT_GAIN    = 32'd19661;

	typedef logic signed [SINE_W-1:0] sine_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_INC,
		ST_AMP_E,
		ST_AMP_O,
		ST_DRV,
		ST_SCALE,
		ST_ANG_E,
		ST_ANG_O,
		ST_ANG_DONE,
		ST_RD_A,
		ST_RD_B,
		ST_DIFF,
		ST_INTERP,
		ST_WEIGHT,
		ST_ACCUM,
		ST_DRIVE,
		ST_X,
		ST_SQ,
		ST_X2,
		ST_NUM,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic               start;
		logic [NUM_W-1:0]   num;
		logic [DEN_W-1:0]   den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [QUOT_W-1:0]  quot;
	} div_rsp_t;

	// taylor series of sin on [0, pi/2], argument in q30
	function automatic longint quarter_sine(longint x);
		longint term;
		longint sum;
		int     k;
		term = x;
		sum  = x;
		for (k = 1; k <= 7; k++) begin
			term = (term * x) >>> 30;
			term = (term * x) >>> 30;
			// divisor is (2k)(2k+1)
			unique case (k)
				1:       term = term / 6;
				2:       term = term / 20;
				3:       term = term / 42;
				4:       term = term / 72;
				5:       term = term / 110;
				6:       term = term / 156;
				default: term = term / 210;
			endcase
			if (k[0])
				sum = sum - term;
			else
				sum = sum + term;
		end
		if (sum < 0)
			sum = 0;
		sum = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
		if (sum > 32767)
			sum = 32767;
		return sum;
	endfunction

	// one full turn, quarter-wave symmetric
	function automatic logic [SINE_N*SINE_W-1:0] build_sine_rom();
		logic [SINE_N*SINE_W-1:0] rom;
		int     i;
		int     quad;
		int     r;
		longint v;
		rom = '0;
		for (i = 0; i < SINE_N; i++) begin
			quad = i >> (SINE_TABLE_BITS - 2);
			r    = i & (SINE_QUARTER - 1);
			if (quad[0])
				r = SINE_QUARTER - r;
			v = quarter_sine((64'sd1686629713 * longint'(r)) >>> (SINE_TABLE_BITS - 2));
			if (quad >= 2)
				v = -v;
			rom[i*SINE_W +: SINE_W] = v[SINE_W-1:0];
		end
		return rom;
	endfunction

	localparam logic [SINE_N*SINE_W-1:0] SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

>>> rtl/mpws_if.sv
// valid/ready channel interfaces for sample in, shaped sample out and configuration
`default_nettype none

interface mpws_in_if import mpws_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       restart;

	modport source (output valid, output sample, output restart, input ready);
	modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface mpws_out_if import mpws_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] shaped;

	modport source (output valid, output shaped, input ready);
	modport sink   (input valid, input shaped, output ready);
endinterface

interface mpws_cfg_if import mpws_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [INTENS_W-1:0] intensity;

	modport source (output valid, output intensity, input ready);
	modport sink   (input valid, input intensity, output ready);
endinterface

`default_nettype wire

>>> rtl/mpws_sine_rom.sv
// sine table rom with registered read data
`default_nettype none

module mpws_sine_rom import mpws_pkg::*; (
	input  logic                       clk,
	input  logic [SINE_TABLE_BITS-1:0] addr,
	output sine_t                      rd_data
);

	sine_t data_q;

	always_ff @(posedge clk) begin
		data_q <= SINE_ROM[{addr, 4'd0} +: SINE_W];
	end

	assign rd_data = data_q;

endmodule

`default_nettype wire

>>> rtl/mpws_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module mpws_div import mpws_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(QUOT_W + 1);

	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [QUOT_W-1:0] sh_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              fits;

	// remainder stays below den, so trial stays below twice den
	assign trial = {rem_q, sh_q[QUOT_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = !diff[DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(QUOT_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					run_q <= 1'b0;
			end
		end
	end

	// numerator low bits shift out while quotient bits shift in
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[NUM_W-1 -: DEN_W];
			sh_q  <= req.num[QUOT_W-1:0];
			den_q <= req.den;
		end else if (run_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			sh_q  <= {sh_q[QUOT_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = sh_q;

endmodule

`default_nettype wire

>>> rtl/metallic_phase_waveshaper_core.sv
// metallic phase waveshaper: sequencer around one shared 32x32 multiplier
//
//  channel | role   | payload                          | transfer
//  cfg     | sink   | intensity[15:0]                  | valid && ready, ready always high
//  din     | sink   | sample[15:0] signed, restart     | valid && ready
//  dout    | source | shaped[15:0] signed              | valid && ready
//
// a din transfer runs through the multiplier and table steps, the 25-step tanh divider
// and the load of the output register before its result reaches dout.
// din.ready is high only in idle, so a new sample waits until the last result is loaded.
// arst_n clears phase and the sequencer and sets intensity to 0.5.
// a result waiting on dout does not hold off the next sample; only the final
// load stalls until the output register is free.
`default_nettype none

module metallic_phase_waveshaper_core import mpws_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mpws_cfg_if.sink   cfg,
	mpws_in_if.sink    din,
	mpws_out_if.source dout
);

	state_t state_q;
	state_t state_d;

	logic [INTENS_W-1:0] intensity_q;
	logic [PHASE_W-1:0]  phase_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] shaped_q;

	logic                s_neg_q;
	logic [SAMPLE_W-1:0] s_mag_q;
	logic [AMP_W-1:0]    ae_q;
	logic [AMP_W-1:0]    ao_q;
	logic [DRV_W-1:0]    drv_q;
	logic [30:0]         sa_q;
	logic [ANGLE_W-1:0]  ang_e_q;
	logic [ANGLE_W-1:0]  ang_o_q;
	logic                sel_q;
	sine_t               a_q;
	logic                dneg_q;
	logic [SINE_W-1:0]   sine_q;
	logic                sneg_q;
	logic [ACC_W-1:0]    acc_q;
	logic                neg_q;
	logic [X_W-1:0]      x_q;
	logic [DEN_W-1:0]    nsum_q;
	logic [DEN_W-1:0]    den_q;
	logic [PROD_W-1:0]   prod_q;

	logic [MUL_W-1:0]    mul_a;
	logic [MUL_W-1:0]    mul_b;
	logic                din_xfer;
	logic                out_load;

	logic [INTENS_W-1:0]        ic;
	logic [29:0]                rnd_sum;
	logic [14:0]                rnd15;
	logic [SPREAD_W-1:0]        spread;
	logic [SPREAD_W-1:0]        mult2;
	logic [49:0]                m1_rnd;
	logic [50:0]                m2_rnd;
	logic [ANGLE_W-1:0]         ang_e_mag;
	logic [ANGLE_W-1:0]         ang_o_mag;
	logic [ANGLE_W-1:0]         cur_ang;
	logic [SINE_TABLE_BITS-1:0] cur_idx;
	logic [FRAC_W-1:0]          cur_frac;
	logic [SINE_TABLE_BITS-1:0] rom_addr;
	sine_t                      rom_data;
	logic [16:0]                diff17;
	logic [16:0]                dmag;
	logic [16:0]                a17;
	logic [16:0]                sine17;
	logic [SINE_W-1:0]          smag;
	logic [ACC_W-1:0]           amag;
	logic [46:0]                x_rnd;
	logic [X2_W-1:0]            x2;
	logic [39:0]                o_rnd;
	logic [SAMPLE_W-1:0]        o_mag;

	div_req_t div_req;
	div_rsp_t div_rsp;

	mpws_sine_rom u_rom (
		.clk     (clk),
		.addr    (rom_addr),
		.rd_data (rom_data)
	);

	mpws_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign din_xfer  = din.valid && din.ready;
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || dout.ready);
	assign cfg.ready = 1'b1;
	assign din.ready = (state_q == ST_IDLE);
	assign dout.valid  = out_valid_q;
	assign dout.shaped = shaped_q;

	// intensity above 1.0 acts as 1.0
	assign ic = (intensity_q > INTENS_MAX) ? INTENS_MAX : intensity_q;

	// q15 coefficient products, rounded
	assign rnd_sum = prod_q[29:0] + 30'd16384;
	assign rnd15   = rnd_sum[29:15];

	assign spread = SPREAD_BASE + {ic, 3'd0} - SPREAD_W'(ic);
	assign mult2  = spread + MULT2_OFS;

	// angle magnitudes, rounded half away from zero, modulo one turn
	assign m1_rnd    = prod_q[49:0] + 50'd32768;
	assign ang_e_mag = m1_rnd[47:16];
	assign m2_rnd    = prod_q[50:0] + 51'd65536;
	assign ang_o_mag = m2_rnd[48:17];

	assign cur_ang  = sel_q ? ang_o_q : ang_e_q;
	assign cur_idx  = cur_ang[ANGLE_W-1 -: SINE_TABLE_BITS];
	assign cur_frac = cur_ang[ANGLE_W-1-SINE_TABLE_BITS -: FRAC_W];

	assign diff17 = {rom_data[SINE_W-1], rom_data} - {a_q[SINE_W-1], a_q};
	assign dmag   = diff17[16] ? (17'd0 - diff17) : diff17;
	assign a17    = {a_q[SINE_W-1], a_q};
	// interpolation step truncates toward zero
	assign sine17 = dneg_q ? (a17 - prod_q[32:16]) : (a17 + prod_q[32:16]);
	assign smag   = sine_q[SINE_W-1] ? (SINE_W'(0) - sine_q) : sine_q;
	assign amag   = acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;

	// x in q24 stays below 1.1, well below the tanh saturation point of 3
	assign x_rnd = prod_q[46:0] + 47'd1048576;
	assign x2    = prod_q[49:24];
	assign o_rnd = prod_q[39:0] + 40'd8388608;
	assign o_mag = o_rnd[39:24];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (din.valid) state_d = ST_INC;
			ST_INC:      state_d = ST_AMP_E;
			ST_AMP_E:    state_d = ST_AMP_O;
			ST_AMP_O:    state_d = ST_DRV;
			ST_DRV:      state_d = ST_SCALE;
			ST_SCALE:    state_d = ST_ANG_E;
			ST_ANG_E:    state_d = ST_ANG_O;
			ST_ANG_O:    state_d = ST_ANG_DONE;
			ST_ANG_DONE: state_d = ST_RD_A;
			ST_RD_A:     state_d = ST_RD_B;
			ST_RD_B:     state_d = ST_DIFF;
			ST_DIFF:     state_d = ST_INTERP;
			ST_INTERP:   state_d = ST_WEIGHT;
			ST_WEIGHT:   state_d = ST_ACCUM;
			ST_ACCUM:    state_d = sel_q ? ST_DRIVE : ST_RD_A;
			ST_DRIVE:    state_d = ST_X;
			ST_X:        state_d = ST_SQ;
			ST_SQ:       state_d = ST_X2;
			ST_X2:       state_d = ST_NUM;
			ST_NUM:      state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_rsp.done) state_d = ST_FIN;
			ST_FIN:      if (out_load) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// operand select for the shared multiplier, rom address, divider start
	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		rom_addr = cur_idx;
		div_req.start = (state_q == ST_DIV_GO);
		div_req.num   = prod_q[NUM_W-1:0];
		div_req.den   = den_q;
		unique case (state_q)
			ST_INC: begin
				mul_a = MUL_W'(ic);
				mul_b = K_PH;
			end
			ST_AMP_E: begin
				mul_a = MUL_W'(ic);
				mul_b = K_AE;
			end
			ST_AMP_O: begin
				mul_a = MUL_W'(ic);
				mul_b = K_AO;
			end
			ST_DRV: begin
				mul_a = MUL_W'(ic);
				mul_b = K_DRV;
			end
			ST_SCALE: begin
				mul_a = MUL_W'(s_mag_q);
				mul_b = TWO_OVER_PI;
			end
			ST_ANG_E: begin
				mul_a = MUL_W'(prod_q[30:0]);
				mul_b = MUL_W'(spread);
			end
			ST_ANG_O: begin
				mul_a = MUL_W'(sa_q);
				mul_b = MUL_W'(mult2);
			end
			ST_RD_B: rom_addr = cur_idx + SINE_TABLE_BITS'(1);
			ST_DIFF: begin
				mul_a = MUL_W'(dmag);
				mul_b = MUL_W'(cur_frac);
			end
			ST_WEIGHT: begin
				mul_a = MUL_W'(smag);
				mul_b = MUL_W'(sel_q ? ao_q : ae_q);
			end
			ST_DRIVE: begin
				mul_a = amag;
				mul_b = MUL_W'(drv_q);
			end
			ST_SQ: begin
				mul_a = MUL_W'(x_q);
				mul_b = MUL_W'(x_q);
			end
			ST_NUM: begin
				mul_a = MUL_W'(x_q);
				mul_b = MUL_W'(nsum_q);
			end
			// output product stays in place while the final load waits
			ST_DIV_WAIT, ST_FIN: begin
				mul_a = MUL_W'(div_rsp.quot);
				mul_b = OUT_GAIN;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			intensity_q <= INTENS_RESET;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid)
				intensity_q <= cfg.intensity;
			// restart clears before the increment lands
			if (din_xfer && din.restart)
				phase_q <= '0;
			else if (state_q == ST_AMP_E)
				phase_q <= phase_q + PH_BASE + PHASE_W'(rnd15);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (dout.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (out_load)
			shaped_q <= neg_q ? (SAMPLE_W'(0) - o_mag) : o_mag;
		unique case (state_q)
			ST_IDLE: begin
				if (din_xfer) begin
					s_neg_q <= din.sample[SAMPLE_W-1];
					s_mag_q <= din.sample[SAMPLE_W-1] ? (SAMPLE_W'(0) - din.sample)
						: din.sample;
				end
			end
			ST_AMP_O:  ae_q <= AE_BASE + rnd15;
			ST_DRV:    ao_q <= AO_BASE + rnd15;
			ST_SCALE:  drv_q <= DRV_BASE + DRV_W'(rnd15);
			ST_ANG_E:  sa_q <= prod_q[30:0];
			ST_ANG_O: begin
				ang_e_q <= (s_neg_q ? (ANGLE_W'(0) - ang_e_mag) : ang_e_mag)
					+ {phase_q, 16'd0};
			end
			ST_ANG_DONE: begin
				ang_o_q <= s_neg_q ? (ANGLE_W'(0) - ang_o_mag) : ang_o_mag;
				sel_q   <= 1'b0;
				acc_q   <= '0;
			end
			ST_RD_B:   a_q <= rom_data;
			ST_DIFF:   dneg_q <= diff17[16];
			ST_INTERP: sine_q <= sine17[SINE_W-1:0];
			ST_WEIGHT: sneg_q <= sine_q[SINE_W-1];
			ST_ACCUM: begin
				acc_q <= sneg_q ? (acc_q - ACC_W'(prod_q[30:0]))
					: (acc_q + ACC_W'(prod_q[30:0]));
				sel_q <= 1'b1;
			end
			ST_DRIVE:  neg_q <= acc_q[ACC_W-1];
			ST_X:      x_q <= x_rnd[45:21];
			ST_X2: begin
				nsum_q <= K27_Q24 + DEN_W'(x2);
				den_q  <= K27_Q24 + DEN_W'({x2, 3'd0}) + DEN_W'(x2);
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/mpws_checker.sv
// port-level assertions for the waveshaper core, bound to the top level
`default_nettype none

module mpws_port_checker import mpws_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [SAMPLE_W-1:0] shaped
);

	// a sample keeps the core busy, so no input is taken in the cycle after a transfer
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken in the cycle after a transfer");

	// a result only appears while a sample is being worked on
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while idle");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(shaped))
		else $error("stalled result changed");

endmodule

bind metallic_phase_waveshaper_core mpws_port_checker u_mpws_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.shaped    (dout.shaped)
);

`default_nettype wire

>>> tb/sv/mpws_checker.sv
// checker for the metallic phase waveshaper: tracks phase and intensity, predicts and compares
`timescale 1ns / 100ps

module mpws_checker import mpws_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	mpws_cfg_if  cfg,
	mpws_in_if   din,
	mpws_out_if  dout,
	output int   errors,
	output int   outstanding
);

	localparam int     TBL_N   = 1 << SINE_TABLE_BITS;
	localparam int     QTR_N   = TBL_N / 4;
	localparam longint ONE_Q24 = 64'sd16777216;

	int                         sine_tbl [TBL_N+1];
	logic signed [SAMPLE_W-1:0] shaped_q [$];
	logic [PHASE_W-1:0]         cur_phase;
	logic [INTENS_W-1:0]        cur_intensity;

	// sin on [0, pi/2] from a q30 angle, taylor series, result in q15
	function automatic int taylor_sin_q15(longint ang);
		longint term;
		longint acc;
		int     k;
		term = ang;
		acc  = ang;
		for (k = 1; k <= 7; k++) begin
			term = (term * ang) >>> 30;
			term = ((term * ang) >>> 30) / longint'((2 * k) * (2 * k + 1));
			if (k[0])
				acc = acc - term;
			else
				acc = acc + term;
		end
		if (acc < 0)
			acc = 0;
		acc = (acc * 32767 + (64'sd1 <<< 29)) >>> 30;
		if (acc > 32767)
			acc = 32767;
		return int'(acc);
	endfunction

	initial begin : fill_sine
		int i;
		int j;
		int quad;
		int r;
		int v;
		for (i = 0; i <= TBL_N; i++) begin
			j    = i % TBL_N;
			quad = j / QTR_N;
			r    = j % QTR_N;
			if (quad % 2 == 1)
				r = QTR_N - r;
			v = taylor_sin_q15(64'sd1686629713 * longint'(r) / longint'(QTR_N));
			sine_tbl[i] = (quad >= 2) ? -v : v;
		end
	end

	// table lookup with linear interpolation, step truncated toward zero
	function automatic int sine_at(logic [31:0] ang);
		int     idx;
		int     a;
		int     b;
		longint frac;
		idx  = int'(ang >> (32 - SINE_TABLE_BITS));
		frac = longint'((ang >> (16 - SINE_TABLE_BITS)) & 32'hFFFF);
		a    = sine_tbl[idx];
		b    = sine_tbl[idx+1];
		return a + int'((longint'(b - a) * frac) / 64'sd65536);
	endfunction

	// s * mult * (2/pi) / 2^sh as a turn fraction, rounded half away from zero
	function automatic logic [31:0] turn_angle(logic signed [SAMPLE_W-1:0] s, longint mult,
			int sh);
		longint      mag;
		logic [63:0] prod;
		logic [31:0] r;
		mag  = (s < 0) ? -longint'(s) : longint'(s);
		prod = 64'(mag * mult) * 64'd41722;
		r    = 32'((prod + (64'd1 << (sh - 1))) >> sh);
		return (s < 0) ? 32'd0 - r : r;
	endfunction

	function automatic longint q15_scale(longint lvl, longint k);
		return (lvl * k + 16384) >>> 15;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] waveshape(logic signed [SAMPLE_W-1:0] s,
			logic [PHASE_W-1:0] ph, longint lvl);
		longint spread;
		longint mult2;
		longint amp_e;
		longint amp_o;
		longint drv;
		longint tot;
		longint mag;
		longint x;
		longint x2;
		longint t;
		longint o;
		int     se;
		int     so;
		logic   neg;
		spread = 98304 + 7 * lvl;
		mult2  = spread + 131072;
		se     = sine_at(turn_angle(s, spread, 16) + {ph, 16'h0000});
		so     = sine_at(turn_angle(s, mult2, 17));
		amp_e  = 8192 + q15_scale(lvl, 9830);
		amp_o  = 4915 + q15_scale(lvl, 6554);
		drv    = 26214 + q15_scale(lvl, 13107);
		tot    = longint'(se) * amp_e + longint'(so) * amp_o;
		neg    = (tot < 0);
		mag    = neg ? -tot : tot;
		x      = (mag * drv + (64'sd1 <<< 20)) >>> 21;
		// rational tanh, flat at one from |x| = 3
		if (x >= 3 * ONE_Q24) begin
			t = ONE_Q24;
		end else begin
			x2 = (x * x) >>> 24;
			t  = (x * (27 * ONE_Q24 + x2)) / (27 * ONE_Q24 + 9 * x2);
		end
		o = (t * 19661 + (64'sd1 <<< 23)) >>> 24;
		if (neg) begin
			if (o > 32768)
				o = 32768;
			return SAMPLE_W'(-o);
		end else begin
			if (o > 32767)
				o = 32767;
			return SAMPLE_W'(o);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic signed [SAMPLE_W-1:0] want;
		longint                     lvl;
		if (!arst_n) begin
			shaped_q.delete();
			cur_phase     = '0;
			cur_intensity = 16'd16384;
			errors        = 0;
			outstanding   = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				cur_intensity = cfg.intensity;
			// results leave before a new sample is queued in the same cycle
			if (dout.valid && dout.ready) begin
				if (shaped_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected shaped result %0d", dout.shaped);
				end else begin
					want = shaped_q.pop_front();
					if (dout.shaped !== want) begin
						errors++;
						if (errors <= 10)
							$display("shaped mismatch: expected %0d, got %0d", want,
								dout.shaped);
					end
				end
			end
			if (din.valid && din.ready) begin
				lvl = (cur_intensity > 16'd32768) ? 64'sd32768 : longint'(cur_intensity);
				if (din.restart)
					cur_phase = '0;
				cur_phase = cur_phase + 16'd1043 + PHASE_W'(q15_scale(lvl, 2608));
				shaped_q.push_back(waveshape(din.sample, cur_phase, lvl));
			end
			outstanding = shaped_q.size();
		end
	end

endmodule

>>> tb/sv/tb.sv
// testbench top: drives samples, intensity writes and output stalls around the waveshaper
`timescale 1ns / 100ps

module tb;
	import mpws_pkg::*;

	localparam int IDLE_LIMIT  = 5000;
	localparam int HOLD_CYCLES = 600;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 90;

	logic                       clk;
	logic                       arst_n;
	int                         errors;
	int                         outstanding;
	int                         burst_left;
	bit                         squeeze;
	logic signed [SAMPLE_W-1:0] ramp;

	mpws_cfg_if cfg_ch ();
	mpws_in_if  din_ch ();
	mpws_out_if dout_ch ();

	metallic_phase_waveshaper_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.din    (din_ch),
		.dout   (dout_ch)
	);

	mpws_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_ch),
		.din         (din_ch),
		.dout        (dout_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// sender bursts: one transfer per call, a random gap when a burst runs out
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic rs);
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 2))
				0:       gap = 0;
				1:       gap = $urandom_range(1, 8);
				default: gap = $urandom_range(9, 70);
			endcase
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				din_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		din_ch.valid   <= 1'b1;
		din_ch.sample  <= s;
		din_ch.restart <= rs;
		@(posedge clk);
		while (!din_ch.ready)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic settle();
		din_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_intensity(input logic [INTENS_W-1:0] v);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.intensity <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return SAMPLE_W'($urandom);
			4, 5:       return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
			6: begin
				case ($urandom_range(0, 3))
					0:       return 16'sh7FFF;
					1:       return 16'sh8000;
					2:       return 16'sh0000;
					default: return -16'sd1;
				endcase
			end
			default: begin
				// slowly moving signal, more like audio
				ramp = ramp + SAMPLE_W'($urandom_range(0, 2047));
				return ramp;
			end
		endcase
	endfunction

	// receiver stall patterns, plus a long hold-off when asked
	initial begin : rx_stall
		int mode;
		int left;
		int k;
		dout_ch.ready <= 1'b0;
		k = 0;
		forever begin
			mode = $urandom_range(0, 4);
			left = $urandom_range(16, 160);
			while (left > 0) begin
				@(posedge clk);
				if (squeeze) begin
					squeeze = 1'b0;
					dout_ch.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end
				case (mode)
					0:       dout_ch.ready <= 1'b1;
					1:       dout_ch.ready <= 1'($urandom_range(0, 1));
					2:       dout_ch.ready <= ($urandom_range(0, 7) != 0);
					3:       dout_ch.ready <= ((k % 6) >= 2);
					default: dout_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
				k++;
				left--;
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stim
		logic [INTENS_W-1:0] level;
		int                  p;
		int                  n;
		arst_n           <= 1'b0;
		din_ch.valid     <= 1'b0;
		din_ch.sample    <= '0;
		din_ch.restart   <= 1'b0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.intensity <= '0;
		burst_left = 0;
		squeeze    = 1'b0;
		ramp       = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed samples at the reset intensity
		send_sample(16'sh0000, 1'b1);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh0001, 1'b0);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sh4000, 1'b0);
		send_sample(16'shC000, 1'b0);
		send_sample(16'sh5555, 1'b0);
		send_sample(16'shAAAA, 1'b0);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh1234, 1'b0);
		send_sample(-16'sd2, 1'b0);

		for (p = 0; p < PHASES; p++) begin
			case (p)
				0:       level = 16'd0;
				1:       level = 16'd32768;
				2:       level = 16'd65535;
				3:       level = 16'd32769;
				4:       level = 16'd1;
				5:       level = 16'd32767;
				6:       level = 16'd16384;
				7, 8:    level = INTENS_W'($urandom);
				default: level = INTENS_W'($urandom_range(0, 32768));
			endcase
			settle();
			write_intensity(level);
			send_sample(16'sh7FFF, 1'b1);
			send_sample(16'sh8000, 1'b0);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// fill the block behind a stalled output
				if ((p == 1 || p == 7) && n == 5)
					squeeze = 1'b1;
				send_sample(pick_sample(), ($urandom_range(0, 15) == 0));
			end
		end

		settle();
		repeat (60) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> metallic_phase_waveshaper_core.f
rtl/mpws_pkg.sv
rtl/mpws_if.sv
rtl/mpws_sine_rom.sv
rtl/mpws_div.sv
rtl/metallic_phase_waveshaper_core.sv
rtl/mpws_checker.sv
tb/sv/mpws_checker.sv
tb/sv/tb.sv
